// ===== design/imk_pkg.sv =====
// shared types, register indexes and the dit length table of the iambic keyer
`default_nettype none

package imk_pkg;

  localparam int TIME_BITS_DEFAULT = 16;
  localparam int CFG_DATA_BITS     = 16;
  localparam int DIT_BITS          = 11;
  localparam int LEN_BITS          = 12;
  localparam int TIMEOUT_BITS      = 16;

  localparam logic [1:0] REG_WPM     = 2'd0;
  localparam logic [1:0] REG_MODE_B  = 2'd1;
  localparam logic [1:0] REG_TIMEOUT = 2'd2;

  localparam logic [1:0] EV_NONE    = 2'd0;
  localparam logic [1:0] EV_DOWN    = 2'd1;
  localparam logic [1:0] EV_UP      = 2'd2;
  localparam logic [1:0] EV_UP_DOWN = 2'd3;

  localparam logic [1:0] PHASE_IDLE  = 2'd0;
  localparam logic [1:0] PHASE_TONE  = 2'd1;
  localparam logic [1:0] PHASE_SPACE = 2'd2;

  localparam logic [DIT_BITS-1:0]     DIT_RESET     = 11'd48;
  localparam logic [TIMEOUT_BITS-1:0] TIMEOUT_RESET = 16'd5000;

  // 1200 / wpm, a wpm of zero reads as 25
  localparam logic [DIT_BITS-1:0] DIT_TABLE [128] = '{
    11'd48,   11'd1200, 11'd600,  11'd400,  11'd300,  11'd240,  11'd200,  11'd171,
    11'd150,  11'd133,  11'd120,  11'd109,  11'd100,  11'd92,   11'd85,   11'd80,
    11'd75,   11'd70,   11'd66,   11'd63,   11'd60,   11'd57,   11'd54,   11'd52,
    11'd50,   11'd48,   11'd46,   11'd44,   11'd42,   11'd41,   11'd40,   11'd38,
    11'd37,   11'd36,   11'd35,   11'd34,   11'd33,   11'd32,   11'd31,   11'd30,
    11'd30,   11'd29,   11'd28,   11'd27,   11'd27,   11'd26,   11'd26,   11'd25,
    11'd25,   11'd24,   11'd24,   11'd23,   11'd23,   11'd22,   11'd22,   11'd21,
    11'd21,   11'd21,   11'd20,   11'd20,   11'd20,   11'd19,   11'd19,   11'd19,
    11'd18,   11'd18,   11'd18,   11'd17,   11'd17,   11'd17,   11'd17,   11'd16,
    11'd16,   11'd16,   11'd16,   11'd16,   11'd15,   11'd15,   11'd15,   11'd15,
    11'd15,   11'd14,   11'd14,   11'd14,   11'd14,   11'd14,   11'd13,   11'd13,
    11'd13,   11'd13,   11'd13,   11'd13,   11'd13,   11'd12,   11'd12,   11'd12,
    11'd12,   11'd12,   11'd12,   11'd12,   11'd12,   11'd11,   11'd11,   11'd11,
    11'd11,   11'd11,   11'd11,   11'd11,   11'd11,   11'd11,   11'd10,   11'd10,
    11'd10,   11'd10,   11'd10,   11'd10,   11'd10,   11'd10,   11'd10,   11'd10,
    11'd10,   11'd9,    11'd9,    11'd9,    11'd9,    11'd9,    11'd9,    11'd9
  };

  typedef struct packed {
    logic dit_paddle;
    logic dah_paddle;
    logic ms_tick;
    logic abort;
  } in_item_t;

  typedef struct packed {
    logic       key_down;
    logic [1:0] key_event;
    logic [1:0] phase;
    logic       element_is_dah;
  } out_item_t;

  typedef struct packed {
    logic [DIT_BITS-1:0]     dit_len;
    logic                    mode_b;
    logic [TIMEOUT_BITS-1:0] timeout;
  } cfg_t;

endpackage

`default_nettype wire

// ===== design/imk_cfg.sv =====
// configuration registers with dit length lookup on a speed write
`default_nettype none

module imk_cfg (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [1:0]                         cfg_index,
  input  wire logic [imk_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  output imk_pkg::cfg_t                           cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dit_len <= imk_pkg::DIT_RESET;
      cfg.mode_b  <= 1'b0;
      cfg.timeout <= imk_pkg::TIMEOUT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        imk_pkg::REG_WPM:     cfg.dit_len <= imk_pkg::DIT_TABLE[cfg_data[6:0]];
        imk_pkg::REG_MODE_B:  cfg.mode_b  <= cfg_data[0];
        imk_pkg::REG_TIMEOUT: cfg.timeout <= cfg_data[imk_pkg::TIMEOUT_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/imk_skid.sv =====
// input register with skid entry, registered stall towards the sender
`default_nettype none

module imk_skid (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire imk_pkg::in_item_t  in_data,
  output logic                    item_valid,
  input  wire logic               item_ready,
  output imk_pkg::in_item_t       item_data
);

  logic              skid_valid;
  imk_pkg::in_item_t skid_data;
  logic              take_in;
  logic              load_main;

  assign in_stall  = skid_valid;
  assign take_in   = in_valid && !skid_valid;
  assign load_main = !item_valid || item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (load_main) begin
      item_valid <= skid_valid || take_in;
      skid_valid <= 1'b0;
    end else if (take_in) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load_main) begin
      item_data <= skid_valid ? skid_data : in_data;
    end else if (take_in) begin
      skid_data <= in_data;
    end
  end

endmodule

`default_nettype wire

// ===== design/imk_core.sv =====
// keyer state, element selection and result register
`default_nettype none

module imk_core #(
  parameter int TIME_BITS = imk_pkg::TIME_BITS_DEFAULT
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire imk_pkg::cfg_t      cfg,
  input  wire logic               item_valid,
  output logic                    item_ready,
  input  wire imk_pkg::in_item_t  item_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output imk_pkg::out_item_t      out_data
);

  localparam int CW = (TIME_BITS > imk_pkg::TIMEOUT_BITS) ? TIME_BITS : imk_pkg::TIMEOUT_BITS;
  localparam logic [TIME_BITS-1:0] TMAX = '1;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'b001,
    PH_TONE  = 3'b010,
    PH_SPACE = 3'b100
  } phase_t;

  typedef enum logic [1:0] {
    SEND_NONE,
    SEND_DIT,
    SEND_DAH
  } send_t;

  typedef struct packed {
    phase_t                          phase;
    logic [TIME_BITS-1:0]            elapsed;
    logic [imk_pkg::LEN_BITS-1:0]    elem_len;
    logic                            last_was_dit;
    logic                            dit_latch;
    logic                            dah_latch;
    logic                            dit_at_tone;
    logic                            dah_at_tone;
    logic                            dit_at_space;
    logic                            dah_at_space;
  } state_t;

  state_t             st;
  state_t             st_next;
  imk_pkg::out_item_t res;
  logic               advance;

  function automatic send_t choose(input state_t s, input logic dl, input logic hl,
                                   input logic mode_b);
    send_t r;
    r = SEND_NONE;
    if (s.last_was_dit || s.phase == PH_IDLE) begin
      if (s.dah_latch || hl) r = SEND_DAH;
      else if (s.dit_latch || dl) r = SEND_DIT;
      else if (mode_b && s.dah_at_tone && !hl && !dl) r = SEND_DAH;
    end else begin
      if (s.dit_latch || dl) r = SEND_DIT;
      else if (s.dah_latch || hl) r = SEND_DAH;
      else if (mode_b && s.dit_at_tone && !dl && !hl) r = SEND_DIT;
    end
    if (s.phase == PH_IDLE && dl && hl) r = SEND_DIT;
    return r;
  endfunction

  function automatic state_t idle_of(input state_t s);
    state_t r;
    r              = s;
    r.phase        = PH_IDLE;
    r.elapsed      = '0;
    r.dit_latch    = 1'b0;
    r.dah_latch    = 1'b0;
    r.dit_at_tone  = 1'b0;
    r.dah_at_tone  = 1'b0;
    r.dit_at_space = 1'b0;
    r.dah_at_space = 1'b0;
    return r;
  endfunction

  function automatic state_t tone_of(input state_t s, input send_t snd, input logic dl,
                                     input logic hl, input logic [imk_pkg::DIT_BITS-1:0] dit);
    state_t r;
    r              = s;
    r.dit_at_tone  = dl;
    r.dah_at_tone  = hl;
    r.dit_latch    = 1'b0;
    r.dah_latch    = 1'b0;
    r.last_was_dit = (snd == SEND_DIT);
    r.phase        = PH_TONE;
    r.elapsed      = '0;
    r.elem_len     = (snd == SEND_DIT) ? {1'b0, dit}
                   : imk_pkg::LEN_BITS'({1'b0, dit, 1'b0} + {2'b00, dit});
    return r;
  endfunction

  function automatic logic [1:0] phase_code(input phase_t p);
    logic [1:0] c;
    unique case (p)
      PH_IDLE:  c = imk_pkg::PHASE_IDLE;
      PH_TONE:  c = imk_pkg::PHASE_TONE;
      PH_SPACE: c = imk_pkg::PHASE_SPACE;
      default:  c = imk_pkg::PHASE_IDLE;
    endcase
    return c;
  endfunction

  always_comb begin
    state_t s;
    logic   dl;
    logic   hl;
    logic   up;
    logic   down;
    send_t  snd;
    s    = st;
    dl   = item_data.dit_paddle;
    hl   = item_data.dah_paddle;
    up   = 1'b0;
    down = 1'b0;
    snd  = SEND_NONE;
    if (item_data.abort) begin
      if (s.phase == PH_TONE) up = 1'b1;
      s = idle_of(s);
    end else begin
      if (s.phase != PH_IDLE && CW'(s.elapsed) > CW'(cfg.timeout)) begin
        if (s.phase == PH_TONE) up = 1'b1;
        s = idle_of(s);
      end
      if (item_data.ms_tick && s.phase != PH_IDLE) begin
        if (s.elapsed != TMAX) s.elapsed = s.elapsed + TIME_BITS'(1);
        if (s.elapsed >= TIME_BITS'(s.elem_len)) begin
          if (s.phase == PH_TONE) begin
            up             = 1'b1;
            s.phase        = PH_SPACE;
            s.elapsed      = '0;
            s.dit_at_space = dl;
            s.dah_at_space = hl;
            s.elem_len     = {1'b0, cfg.dit_len};
          end else begin
            snd = choose(s, dl, hl, cfg.mode_b);
            if (snd != SEND_NONE) begin
              s    = tone_of(s, snd, dl, hl, cfg.dit_len);
              down = 1'b1;
            end else begin
              s = idle_of(s);
            end
          end
        end
      end
      if (s.phase == PH_IDLE) begin
        if (dl || hl) begin
          snd = choose(s, dl, hl, cfg.mode_b);
          if (snd != SEND_NONE) begin
            s    = tone_of(s, snd, dl, hl, cfg.dit_len);
            down = 1'b1;
          end
        end
      end else if (s.phase == PH_TONE) begin
        if (s.last_was_dit && hl && !s.dah_at_tone) s.dah_latch = 1'b1;
        if (!s.last_was_dit && dl && !s.dit_at_tone) s.dit_latch = 1'b1;
      end else begin
        if (dl && !s.dit_at_space) s.dit_latch = 1'b1;
        if (hl && !s.dah_at_space) s.dah_latch = 1'b1;
      end
    end
    st_next            = s;
    res.key_down       = (s.phase == PH_TONE);
    res.key_event      = {up, down};
    res.phase          = phase_code(s.phase);
    res.element_is_dah = !s.last_was_dit;
  end

  assign item_ready = !out_valid || !out_stall;
  assign advance    = item_valid && item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase        <= PH_IDLE;
      st.elapsed      <= '0;
      st.elem_len     <= '0;
      st.last_was_dit <= 1'b0;
      st.dit_latch    <= 1'b0;
      st.dah_latch    <= 1'b0;
      st.dit_at_tone  <= 1'b0;
      st.dah_at_tone  <= 1'b0;
      st.dit_at_space <= 1'b0;
      st.dah_at_space <= 1'b0;
      out_valid       <= 1'b0;
    end else if (advance) begin
      st        <= st_next;
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst && advance) begin
      out_data <= res;
    end
  end

  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    st.phase == PH_IDLE |-> (st.elapsed == '0 && !st.dit_latch && !st.dah_latch
                             && !st.dit_at_tone && !st.dah_at_tone))
    else $error("idle phase with live timing or latches");

  a_abort_idle: assert property (@(posedge clk) disable iff (rst)
    advance && item_data.abort |=> st.phase == PH_IDLE)
    else $error("abort did not return to idle");

  a_result_phase: assert property (@(posedge clk) disable iff (rst)
    $past(advance && !rst) |-> out_data.phase == phase_code(st.phase))
    else $error("result phase disagrees with keyer state");

  a_down_keyed: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.key_event[0] |-> out_data.key_down)
    else $error("key down transaction without key level");

endmodule

`default_nettype wire

// ===== design/iambic_morse_keyer.sv =====
// top level of the iambic morse keyer
`default_nettype none

// Iambic keyer (modes A and B): one input transaction per cycle while neither side stalls,
// each producing exactly one result transaction through the input and result registers.
// The input side has a registered stall (skid entry), and the result register separates the
// output side, so the sustained rate of one transaction per clock is set by the combinational
// element decision between them. Registers: 0 words per minute (dit length looked up from a
// 128-entry table at write time), 1 mode B, 2 safety timeout in ticks; write only while idle.
module iambic_morse_keyer #(
  parameter int TIME_BITS = imk_pkg::TIME_BITS_DEFAULT
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire imk_pkg::in_item_t                 in_data,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output imk_pkg::out_item_t                     out_data,
  input  wire logic                              cfg_we,
  input  wire logic [1:0]                        cfg_index,
  input  wire logic [imk_pkg::CFG_DATA_BITS-1:0] cfg_data
);

  imk_pkg::cfg_t     cfg;
  logic              item_valid;
  logic              item_ready;
  imk_pkg::in_item_t item_data;

  imk_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  imk_skid u_skid (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item_data  (item_data)
  );

  imk_core #(
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item_data  (item_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

`default_nettype wire
